// File: rtl/psc_pkg.sv
package psc_pkg;

  localparam int NUM_SIGS = 7;
  localparam int WIN_DEPTH = 24;
  localparam int POS_W = 13;
  localparam int OFS_W = POS_W + 1;
  localparam int HS_W = 6;
  localparam logic [HS_W-1:0] HS_RESET = HS_W'(14);

  localparam int SCAN_LEN_DEF = 512;
  localparam int WINDOW_LEN_DEF = 32;

  localparam int SIG_URI_RPC = 0;
  localparam int SIG_URI_MAIN = 1;
  localparam int SIG_BEANUTILS = 2;
  localparam int SIG_COLLECTIONS = 3;
  localparam int SIG_JDBC = 4;
  localparam int SIG_ROME = 5;
  localparam int SIG_METHOD_CALL = 6;

  // right-justified text, first character in the highest used byte
  localparam logic [8*WIN_DEPTH-1:0] SIG_TEXT [NUM_SIGS] = '{
    "/webtools/control/xmlrpc",
    "/webtools/control/main",
    "CommonsBeanutils",
    "CommonsCollections",
    "JdbcRowSetImpl",
    "ROME",
    "methodCall"
  };
  localparam int SIG_LEN [NUM_SIGS] = '{24, 22, 16, 18, 14, 4, 10};

  typedef enum logic [2:0] {
    KIND_NONE        = 3'd0,
    KIND_BEANUTILS   = 3'd1,
    KIND_COLLECTIONS = 3'd2,
    KIND_JDBC        = 3'd3,
    KIND_ROME        = 3'd4
  } psc_kind_e;

  typedef struct packed {
    logic [7:0]          data_byte;
    logic                last;
    logic                scan;
    logic [NUM_SIGS-1:0] eligible;
  } psc_item_t;

  typedef struct packed {
    logic      uri_hit;
    psc_kind_e gadget_kind;
    logic      alert;
  } psc_verdict_t;

endpackage

// File: rtl/psc_matcher.sv
module psc_matcher (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  psc_pkg::psc_item_t   item_i,
  output psc_pkg::psc_verdict_t verdict_o
);

  logic [8*psc_pkg::WIN_DEPTH-1:0] win_q;
  logic [8*psc_pkg::WIN_DEPTH-1:0] win_d;
  logic [psc_pkg::NUM_SIGS-1:0]    found_q;
  logic [psc_pkg::NUM_SIGS-1:0]    found_d;
  logic [psc_pkg::NUM_SIGS-1:0]    hit;

  // newest byte in the lowest byte lane
  assign win_d = {win_q[8*psc_pkg::WIN_DEPTH-9:0], item_i.data_byte};

  for (genvar k = 0; k < psc_pkg::NUM_SIGS; k++) begin : g_sig
    localparam int Len = psc_pkg::SIG_LEN[k];
    assign hit[k] = item_i.scan && item_i.eligible[k]
                    && (win_d[8*Len-1:0] == psc_pkg::SIG_TEXT[k][8*Len-1:0]);
  end

  assign found_d = found_q | hit;

  always_comb begin
    verdict_o.uri_hit = found_d[psc_pkg::SIG_URI_RPC] | found_d[psc_pkg::SIG_URI_MAIN];
    if (found_d[psc_pkg::SIG_BEANUTILS]) begin
      verdict_o.gadget_kind = psc_pkg::KIND_BEANUTILS;
    end else if (found_d[psc_pkg::SIG_COLLECTIONS]) begin
      verdict_o.gadget_kind = psc_pkg::KIND_COLLECTIONS;
    end else if (found_d[psc_pkg::SIG_JDBC]) begin
      verdict_o.gadget_kind = psc_pkg::KIND_JDBC;
    end else if (found_d[psc_pkg::SIG_ROME] && found_d[psc_pkg::SIG_METHOD_CALL]) begin
      verdict_o.gadget_kind = psc_pkg::KIND_ROME;
    end else begin
      verdict_o.gadget_kind = psc_pkg::KIND_NONE;
    end
    verdict_o.alert = verdict_o.uri_hit && (verdict_o.gadget_kind != psc_pkg::KIND_NONE);
  end

  // stale window bytes are never compared: eligibility needs the whole match in payload
  always_ff @(posedge clk_i) begin
    if (step_i && item_i.scan) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= '0;
    end else if (step_i) begin
      if (item_i.last) begin
        found_q <= '0;
      end else begin
        found_q <= found_d;
      end
    end
  end

endmodule

// File: rtl/packet_signature_classifier.sv
// packet signature classifier
// input stream: one packet byte per transfer in s_axis_tdata_i, s_axis_tlast_i on the
// final byte of the packet. the first header_skip bytes are skipped, then up to
// SCAN_LEN payload bytes are searched for two uri paths and five gadget markers.
// output stream: one verdict transfer per packet, issued after its last byte.
// header_skip is written through cfg_we_i / cfg_wdata_i; the user must do so only
// while the block is idle, which the block does not enforce. throughput: one byte
// per cycle unless a waiting verdict holds the input side; the comparator bank
// checks every pattern against the window while the byte sits in the input register.
// a verdict is registered in the output register, which drives m_axis_tvalid_o.
// reset clears the byte position, the found flags, both pipeline stages and
// sets header_skip to 14; s_axis_tready_o is high as soon as reset is released.
// when the receiver stalls, the verdict waits in the output register; bytes of
// the next packet keep flowing until its own last byte reaches the input register,
// which then holds the input side until the waiting verdict is taken.
module packet_signature_classifier #(
  parameter int SCAN_LEN   = psc_pkg::SCAN_LEN_DEF,
  parameter int WINDOW_LEN = psc_pkg::WINDOW_LEN_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [7:0]                s_axis_tdata_i,   // [7:0] data_byte
  input  logic                      s_axis_tlast_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [7:0]                m_axis_tdata_o,   // [0] alert, [3:1] gadget_kind,
                                                      // [4] uri_hit, [7:5] zero
  input  logic                      cfg_we_i,
  input  logic [psc_pkg::HS_W-1:0]  cfg_wdata_i
);

  localparam int OfsW = psc_pkg::OFS_W;
  localparam logic [OfsW-1:0] ScanLim = OfsW'(SCAN_LEN);

  logic [psc_pkg::HS_W-1:0]  hs_q;
  logic [psc_pkg::POS_W-1:0] pos_q;
  logic                      in_fire;
  logic                      in_payload;
  logic [OfsW-1:0]           ofs;
  psc_pkg::psc_item_t        item_d;
  psc_pkg::psc_item_t        item_a_q;
  logic                      valid_a_q;
  logic                      adv_a;
  psc_pkg::psc_verdict_t     verdict;
  psc_pkg::psc_verdict_t     out_q;
  logic                      out_valid_q;

  assign in_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign in_payload = pos_q >= psc_pkg::POS_W'(hs_q);
  assign ofs        = OfsW'(pos_q) - OfsW'(hs_q);

  for (genvar k = 0; k < psc_pkg::NUM_SIGS; k++) begin : g_elig
    localparam logic [OfsW-1:0] Lo = OfsW'(psc_pkg::SIG_LEN[k] - 1);
    localparam logic [OfsW-1:0] Hi = OfsW'(SCAN_LEN - WINDOW_LEN + psc_pkg::SIG_LEN[k] - 1);
    assign item_d.eligible[k] = (ofs >= Lo) && (ofs < Hi);
  end

  assign item_d.data_byte = s_axis_tdata_i;
  assign item_d.last      = s_axis_tlast_i;
  assign item_d.scan      = in_payload && (ofs < ScanLim);

  // a last byte moves on only when the output register can take its verdict
  assign adv_a = valid_a_q && (!item_a_q.last || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !valid_a_q || adv_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q <= psc_pkg::HS_RESET;
    end else if (cfg_we_i) begin
      hs_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_fire) begin
      if (s_axis_tlast_i) begin
        pos_q <= '0;
      end else if (pos_q != '1) begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (in_fire) begin
      valid_a_q <= 1'b1;
    end else if (adv_a) begin
      valid_a_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_a_q <= item_d;
    end
  end

  psc_matcher u_matcher (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv_a),
    .item_i    (item_a_q),
    .verdict_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_a && item_a_q.last) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a && item_a_q.last) begin
      out_q <= verdict;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.uri_hit, out_q.gadget_kind, out_q.alert};

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> valid_a_q && item_a_q.last && out_valid_q)
    else $error("input stalled without a waiting verdict");

  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && s_axis_tlast_i |=> pos_q == '0)
    else $error("byte position not cleared after last byte");

  a_verdict_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(valid_a_q && item_a_q.last))
    else $error("verdict without a last byte");

  a_alert_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.alert |-> out_q.uri_hit && out_q.gadget_kind != psc_pkg::KIND_NONE)
    else $error("alert without uri and gadget");

endmodule

// File: test/psc_verdict_checker.sv
`timescale 1ns / 100ps

module psc_verdict_checker
  import psc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_valid_i,
  input  logic            byte_ready_i,
  input  logic [7:0]      byte_data_i,
  input  logic            byte_last_i,
  input  logic            verdict_valid_i,
  input  logic            verdict_ready_i,
  input  logic [7:0]      verdict_data_i,
  input  logic            cfg_we_i,
  input  logic [HS_W-1:0] cfg_wdata_i,
  output int              pending_o,
  output int              errors_o
);

  localparam int SCAN_BYTES = 512;
  localparam int MATCH_GUARD = 32;
  localparam int POS_CEILING = 8191;
  localparam int SKIP_AT_RESET = 14;

  string sig_text [NUM_SIGS] = '{
    "/webtools/control/xmlrpc",
    "/webtools/control/main",
    "CommonsBeanutils",
    "CommonsCollections",
    "JdbcRowSetImpl",
    "ROME",
    "methodCall"
  };

  logic [HS_W-1:0]     hdr_skip;
  logic [7:0]          win [WIN_DEPTH];
  int                  pos;
  logic [NUM_SIGS-1:0] found;
  psc_verdict_t        verdict_q [$];
  int                  err_cnt = 0;

  function automatic bit ends_at_newest(int k);
    int n;
    int j;
    n = sig_text[k].len();
    for (j = 0; j < n; j++) begin
      if (win[n-1-j] != sig_text[k][j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic psc_verdict_t classify(logic [NUM_SIGS-1:0] f);
    psc_verdict_t v;
    v.uri_hit = f[SIG_URI_RPC] | f[SIG_URI_MAIN];
    if (f[SIG_BEANUTILS]) begin
      v.gadget_kind = KIND_BEANUTILS;
    end else if (f[SIG_COLLECTIONS]) begin
      v.gadget_kind = KIND_COLLECTIONS;
    end else if (f[SIG_JDBC]) begin
      v.gadget_kind = KIND_JDBC;
    end else if (f[SIG_ROME] && f[SIG_METHOD_CALL]) begin
      v.gadget_kind = KIND_ROME;
    end else begin
      v.gadget_kind = KIND_NONE;
    end
    v.alert = v.uri_hit && (v.gadget_kind != KIND_NONE);
    return v;
  endfunction

  task automatic forget_packet();
    int i;
    for (i = 0; i < WIN_DEPTH; i++) win[i] = 8'h00;
    pos = 0;
    found = '0;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin : track
    int q;
    int k;
    int n;
    int i;
    psc_verdict_t want;
    psc_verdict_t got;
    if (!rst_ni) begin
      hdr_skip = HS_W'(SKIP_AT_RESET);
      forget_packet();
      verdict_q.delete();
      pending_o <= 0;
      errors_o <= err_cnt;
    end else begin
      if (cfg_we_i) hdr_skip = cfg_wdata_i;
      if (byte_valid_i && byte_ready_i) begin
        if (pos >= int'(hdr_skip)) begin
          q = pos - int'(hdr_skip);
          if (q < SCAN_BYTES) begin
            for (i = WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
            win[0] = byte_data_i;
            for (k = 0; k < NUM_SIGS; k++) begin
              n = sig_text[k].len();
              if (q + 1 >= n && q + 1 - n < SCAN_BYTES - MATCH_GUARD && ends_at_newest(k))
                found[k] = 1'b1;
            end
          end
        end
        if (pos < POS_CEILING) pos++;
        if (byte_last_i) begin
          verdict_q.push_back(classify(found));
          forget_packet();
        end
      end
      if (verdict_valid_i && verdict_ready_i) begin
        got = psc_verdict_t'(verdict_data_i[4:0]);
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict transfer with none pending, data", verdict_data_i, 0);
        end else begin
          want = verdict_q.pop_front();
          if (got.alert != want.alert) report_mismatch("alert", got.alert, want.alert);
          if (got.gadget_kind != want.gadget_kind)
            report_mismatch("gadget_kind", got.gadget_kind, want.gadget_kind);
          if (got.uri_hit != want.uri_hit) report_mismatch("uri_hit", got.uri_hit, want.uri_hit);
          if (verdict_data_i[7:5] != 3'b000) report_mismatch("pad bits", verdict_data_i[7:5], 0);
        end
      end
      pending_o <= verdict_q.size();
      errors_o <= err_cnt;
    end
  end

endmodule

// File: test/packet_signature_classifier_tb.sv
`timescale 1ns / 100ps

module packet_signature_classifier_tb;
  import psc_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic            clk_i;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid_i = 1'b0;
  logic            s_axis_tready_o;
  logic [7:0]      s_axis_tdata_i = 8'h00;  // [7:0] data_byte
  logic            s_axis_tlast_i = 1'b0;
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i = 1'b0;
  logic [7:0]      m_axis_tdata_o;          // [0] alert, [3:1] gadget_kind, [4] uri_hit
  logic            cfg_we_i = 1'b0;
  logic [HS_W-1:0] cfg_wdata_i = '0;

  int              pending;
  int              errors;

  logic [7:0]      pkt [$];
  logic [HS_W-1:0] hs_now = HS_W'(14);
  bit              tx_idle = 1'b0;
  bit              rx_idle = 1'b1;
  bit              hold_req = 1'b0;

  packet_signature_classifier i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  psc_verdict_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .byte_valid_i    (s_axis_tvalid_i),
    .byte_ready_i    (s_axis_tready_o),
    .byte_data_i     (s_axis_tdata_i),
    .byte_last_i     (s_axis_tlast_i),
    .verdict_valid_i (m_axis_tvalid_o),
    .verdict_ready_i (m_axis_tready_i),
    .verdict_data_i  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .pending_o       (pending),
    .errors_o        (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
          (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("packet_signature_classifier_tb: FAIL");
    $finish;
  end

  // verdict sink, with random back-pressure and one long hold on request
  initial begin : sink
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = rx_idle ? $urandom_range(0, 12) : 0;
      end
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      if ($urandom_range(0, 15) == 0) rx_idle = !rx_idle;
    end
  end

  task automatic put_byte(logic [7:0] b, logic last);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    s_axis_tlast_i <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic send_packet(bit may_idle);
    int i;
    tx_idle = may_idle && ($urandom_range(0, 3) != 0);
    for (i = 0; i < pkt.size(); i++) put_byte(pkt[i], i == pkt.size() - 1);
    pkt.delete();
  endtask

  task automatic add_noise(int n);
    repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  // broken markers are either cut short by one byte or carry one corrupted byte
  task automatic add_sig(int k, bit broken);
    int n;
    int j;
    int bad;
    logic [7:0] c;
    n = SIG_LEN[k];
    bad = broken ? $urandom_range(0, n - 1) : -1;
    if (broken && $urandom_range(0, 1) == 1) begin
      n--;
      bad = -1;
    end
    for (j = 0; j < n; j++) begin
      c = SIG_TEXT[k][8*(SIG_LEN[k]-1-j) +: 8];
      if (j == bad) c = c ^ 8'($urandom_range(1, 255));
      pkt.push_back(c);
    end
  endtask

  function automatic int pick_sig();
    if ($urandom_range(0, 1) == 1) return $urandom_range(SIG_BEANUTILS, SIG_METHOD_CALL);
    return $urandom_range(SIG_URI_RPC, SIG_URI_MAIN);
  endfunction

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_header(logic [HS_W-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hs_now = v;
  endtask

  task automatic random_packet();
    int lead;
    int pieces;
    int r;
    lead = ($urandom_range(0, 4) == 0) ? $urandom_range(0, hs_now) : hs_now;
    add_noise(lead);
    pieces = $urandom_range(0, 3);
    repeat (pieces) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        add_sig(pick_sig(), 1'b0);
      end else if (r < 5) begin
        add_sig(pick_sig(), 1'b1);
      end else begin
        add_noise($urandom_range(0, 5));
      end
    end
    if (pkt.size() == 0) add_noise(1);
  endtask

  task automatic random_phase(int count);
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) drain();
      random_packet();
      send_packet(1'b1);
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-byte packet
    pkt.push_back(8'hFF);
    send_packet(1'b1);
    // markers only inside a header that fills the whole packet
    add_sig(SIG_ROME, 1'b0);
    add_sig(SIG_METHOD_CALL, 1'b0);
    send_packet(1'b1);
    add_noise(hs_now);
    add_sig(SIG_URI_RPC, 1'b0);
    add_sig(SIG_BEANUTILS, 1'b0);
    send_packet(1'b1);
    // uri starting inside the header
    add_noise(hs_now - 2);
    add_sig(SIG_URI_MAIN, 1'b0);
    add_sig(SIG_COLLECTIONS, 1'b0);
    send_packet(1'b1);

    set_header('0);
    add_sig(SIG_ROME, 1'b0);
    add_sig(SIG_URI_RPC, 1'b0);
    send_packet(1'b1);
    add_sig(SIG_METHOD_CALL, 1'b0);
    add_noise(3);
    add_sig(SIG_ROME, 1'b0);
    add_sig(SIG_URI_MAIN, 1'b0);
    send_packet(1'b1);
    // several gadgets, priority picks the highest-ranked kind, not the first in the packet
    add_sig(SIG_URI_MAIN, 1'b0);
    pkt.push_back(8'h00);
    pkt.push_back(8'hFF);
    add_sig(SIG_COLLECTIONS, 1'b0);
    add_sig(SIG_BEANUTILS, 1'b0);
    send_packet(1'b1);
    add_sig(SIG_JDBC, 1'b0);
    add_sig(SIG_ROME, 1'b0);
    add_sig(SIG_METHOD_CALL, 1'b0);
    send_packet(1'b1);
    // marker split across two packets
    add_sig(SIG_ROME, 1'b0);
    void'(pkt.pop_back());
    send_packet(1'b1);
    pkt.push_back(SIG_TEXT[SIG_ROME][7:0]);
    add_sig(SIG_METHOD_CALL, 1'b0);
    send_packet(1'b1);
    // markers from the first payload byte to the last
    add_sig(SIG_ROME, 1'b0);
    add_sig(SIG_METHOD_CALL, 1'b0);
    send_packet(1'b1);

    // long sink hold while short packets keep coming back to back
    drain();
    hold_req = 1'b1;
    repeat (8) begin
      add_noise($urandom_range(1, 3));
      send_packet(1'b0);
    end

    // largest header, marker straddling its end
    set_header(HS_W'(63));
    add_noise(62);
    add_sig(SIG_ROME, 1'b0);
    send_packet(1'b1);

    repeat (2) begin
      set_header(HS_W'($urandom_range(1, 8)));
      random_phase(2);
    end

    drain();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    if (errors == 0) begin
      $display("packet_signature_classifier_tb: PASS");
    end else begin
      $display("packet_signature_classifier_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/psc_pkg.sv
rtl/psc_matcher.sv
rtl/packet_signature_classifier.sv
test/psc_verdict_checker.sv
test/packet_signature_classifier_tb.sv
